### rtl/core/gwwl_pkg.sv
// ----------------------------------------------------------------------------
// gwwl_pkg
// Shared types, constants and saturating helpers for the greedy word-wrap
// glyph placer.
// ----------------------------------------------------------------------------
package gwwl_pkg;

  // Word buffer depth and pen position width
  localparam int WORD_DEPTH = 64;
  localparam int POS_BITS   = 32;

  localparam int ADDR_W = $clog2(WORD_DEPTH);
  localparam int LEN_W  = $clog2(WORD_DEPTH + 1);
  localparam int SUM_W  = ((POS_BITS > 24) ? POS_BITS : 24) + 1;
  localparam int CMP_W  = (POS_BITS > 32) ? POS_BITS : 32;
  localparam int CLP_W  = POS_BITS + 32;

  localparam logic [POS_BITS-1:0] POS_MAX = '1;

  // Glyph classes
  localparam logic [1:0] CLS_ORDINARY = 2'd0;
  localparam logic [1:0] CLS_SPACE    = 2'd1;
  localparam logic [1:0] CLS_NEWLINE  = 2'd2;

  // Register indexes
  localparam logic [1:0] REG_FIRST_INDENT = 2'd0;
  localparam logic [1:0] REG_LINE_STEP    = 2'd1;
  localparam logic [1:0] REG_WRAP_WIDTH   = 2'd2;

  // Register reset values
  localparam logic [23:0] FIRST_INDENT_RST = 24'd0;
  localparam logic [23:0] LINE_STEP_RST    = 24'd7168;
  localparam logic [31:0] WRAP_WIDTH_RST   = 32'hFFFF_FFFF;
  localparam logic [31:0] NO_WRAP          = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [1:0]  glyph_class;
    logic [15:0] advance;
    logic        next_breaks;
    logic        first_glyph;
  } glyph_in_t;

  typedef struct packed {
    logic [15:0] glyph_index;
    logic [31:0] pos_x;
    logic [31:0] pos_y;
    logic        placed;
    logic        word_overflow;
    logic        last;
  } glyph_out_t;

  // Saturating pen add of a value of up to 24 bits
  function automatic logic [POS_BITS-1:0] sat_add(input logic [POS_BITS-1:0] a,
                                                  input logic [23:0] b);
    logic [SUM_W-1:0] s;
    s = SUM_W'(a) + SUM_W'(b);
    if (s > SUM_W'(POS_MAX)) begin
      return POS_MAX;
    end
    return s[POS_BITS-1:0];
  endfunction

  // Clamp a 24-bit value into the pen range
  function automatic logic [POS_BITS-1:0] clamp_pos(input logic [23:0] v);
    if (SUM_W'(v) > SUM_W'(POS_MAX)) begin
      return POS_MAX;
    end
    return POS_BITS'(v);
  endfunction

  // Clamp a pen position to the 32-bit output field
  function automatic logic [31:0] clamp_out(input logic [POS_BITS-1:0] v);
    logic [CLP_W-1:0] w;
    w = CLP_W'(v);
    if (w > CLP_W'(32'hFFFF_FFFF)) begin
      return 32'hFFFF_FFFF;
    end
    return w[31:0];
  endfunction

endpackage

### rtl/core/greedy_word_wrap_layout_core.sv
// A space, newline or unwrapped glyph is held in item_r, and S_EXEC writes its result
//   to the output register once the output slot is free; no new item is taken until
//   the sequencer is back in S_IDLE. A wrap re-places the word through one saturating
//   adder and the RAM read port, S_RD then S_EMIT per glyph; output stalls hold it.
// Reset (rst_n low, synchronous) clears pen, counters, sequencer and registers;
//   the word RAM is not cleared and needs no sweep.
// ----------------------------------------------------------------------------
// greedy_word_wrap_layout_core
// Places glyphs one at a time with greedy word wrapping, keeping the pen
// position and the advances of the current word in a small RAM.
// ----------------------------------------------------------------------------
module greedy_word_wrap_layout_core (
  input  logic                  clk,
  input  logic                  rst_n,
  // Glyph input channel
  input  logic                  in_valid,
  output logic                  in_ready,
  input  gwwl_pkg::glyph_in_t   in_data,
  // Result channel
  output logic                  out_valid,
  input  logic                  out_ready,
  output gwwl_pkg::glyph_out_t  out_data,
  // Configuration port
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [3:0]            paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  import gwwl_pkg::*;

  // Sequencer codes
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EXEC = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EMIT = 3'd3;
  localparam logic [2:0] S_TAIL = 3'd4;

  logic [2:0]          state_r, state_nxt;
  logic [23:0]         first_indent_r;
  logic [23:0]         line_step_r;
  logic [31:0]         wrap_width_r;

  logic [POS_BITS-1:0] pen_x_r, pen_x_nxt;
  logic [POS_BITS-1:0] pen_y_r, pen_y_nxt;
  logic [LEN_W-1:0]    word_len_r, word_len_nxt;
  logic                word_over_r, word_over_nxt;
  logic [15:0]         word_first_r, word_first_nxt;
  logic [15:0]         next_index_r, next_index_nxt;

  glyph_in_t           item_r, item_nxt;
  logic [15:0]         idx_r, idx_nxt;
  logic [LEN_W-1:0]    k_r, k_nxt;
  logic [LEN_W-1:0]    cnt_r, cnt_nxt;
  logic                ovf_r, ovf_nxt;

  logic                out_valid_r, out_valid_nxt;
  glyph_out_t          out_data_r, out_data_nxt;

  logic                slot_free;
  logic                cfg_wr;
  logic [POS_BITS-1:0] add_a;
  logic [23:0]         add_b;
  logic [POS_BITS-1:0] add_sum;
  logic                over_limit;
  logic                ram_we;
  logic [15:0]         ram_rdata;

  // Configuration writes and reads
  assign cfg_wr = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_indent_r <= FIRST_INDENT_RST;
      line_step_r    <= LINE_STEP_RST;
      wrap_width_r   <= WRAP_WIDTH_RST;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_FIRST_INDENT: first_indent_r <= pwdata[23:0];
        REG_LINE_STEP:    line_step_r    <= pwdata[23:0];
        REG_WRAP_WIDTH:   wrap_width_r   <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_FIRST_INDENT: prdata = {8'd0, first_indent_r};
      REG_LINE_STEP:    prdata = {8'd0, line_step_r};
      REG_WRAP_WIDTH:   prdata = wrap_width_r;
      default:          prdata = 32'd0;
    endcase
  end

  // Word advance buffer
  gwwl_ram #(
    .WIDTH (16),
    .DEPTH (WORD_DEPTH)
  ) u_word_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (word_len_r[ADDR_W-1:0]),
    .wdata (item_r.advance),
    .raddr (k_r[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Output slot is free when empty or being drained this cycle
  assign slot_free = !out_valid_r || out_ready;
  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Shared saturating adder: operand chosen by the sequencer
  always_comb begin
    add_a = pen_x_r;
    add_b = {8'd0, item_r.advance};
    if (state_r == S_EMIT) begin
      add_b = {8'd0, ram_rdata};
    end
  end
  assign add_sum = sat_add(add_a, add_b);

  // Line limit check on the advanced pen
  assign over_limit = item_r.next_breaks && (wrap_width_r != NO_WRAP) &&
                      (CMP_W'(add_sum) > CMP_W'(wrap_width_r));

  assign ram_we = (state_r == S_EXEC) && slot_free &&
                  (item_r.glyph_class != CLS_SPACE) &&
                  (item_r.glyph_class != CLS_NEWLINE) &&
                  (word_len_r < LEN_W'(WORD_DEPTH));

  // Sequencer and datapath next state
  always_comb begin
    state_nxt      = state_r;
    pen_x_nxt      = pen_x_r;
    pen_y_nxt      = pen_y_r;
    word_len_nxt   = word_len_r;
    word_over_nxt  = word_over_r;
    word_first_nxt = word_first_r;
    next_index_nxt = next_index_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    k_nxt          = k_r;
    cnt_nxt        = cnt_r;
    ovf_nxt        = ovf_r;
    out_valid_nxt  = out_valid_r && !out_ready;
    out_data_nxt   = out_data_r;

    case (state_r)
      S_IDLE: begin
        // Take the transaction; a new text resets pen and counters
        if (in_valid) begin
          item_nxt = in_data;
          if (in_data.first_glyph) begin
            pen_x_nxt      = clamp_pos(first_indent_r);
            pen_y_nxt      = '0;
            word_len_nxt   = '0;
            word_over_nxt  = 1'b0;
            word_first_nxt = '0;
            idx_nxt        = '0;
            next_index_nxt = 16'd1;
          end else begin
            idx_nxt        = next_index_r;
            next_index_nxt = next_index_r + 16'd1;
          end
          state_nxt = S_EXEC;
        end
      end

      S_EXEC: begin
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.glyph_index   = idx_r;
          out_data_nxt.pos_x         = clamp_out(pen_x_r);
          out_data_nxt.pos_y         = clamp_out(pen_y_r);
          out_data_nxt.placed        = 1'b1;
          out_data_nxt.word_overflow = 1'b0;
          out_data_nxt.last          = 1'b1;
          state_nxt                  = S_IDLE;
          case (item_r.glyph_class)
            CLS_SPACE: begin
              // End the word; skip a space at the line start
              word_len_nxt   = '0;
              word_over_nxt  = 1'b0;
              word_first_nxt = idx_r + 16'd1;
              if (pen_x_r == '0) begin
                out_data_nxt.placed = 1'b0;
              end else if (over_limit) begin
                pen_x_nxt = '0;
                pen_y_nxt = sat_add(pen_y_r, line_step_r);
              end else begin
                pen_x_nxt = add_sum;
              end
            end
            CLS_NEWLINE: begin
              pen_x_nxt      = '0;
              pen_y_nxt      = sat_add(pen_y_r, line_step_r);
              word_len_nxt   = '0;
              word_over_nxt  = 1'b0;
              word_first_nxt = idx_r + 16'd1;
            end
            default: begin
              // Buffer the advance or mark the word as overflowed
              if (word_len_r < LEN_W'(WORD_DEPTH)) begin
                word_len_nxt = word_len_r + LEN_W'(1);
              end else begin
                word_over_nxt = 1'b1;
              end
              if (over_limit) begin
                // Start a wrap: drop the single result, replay the word
                out_valid_nxt = out_valid_r && !out_ready;
                out_data_nxt  = out_data_r;
                pen_x_nxt     = '0;
                pen_y_nxt     = sat_add(pen_y_r, line_step_r);
                k_nxt         = '0;
                if (word_len_r < LEN_W'(WORD_DEPTH)) begin
                  ovf_nxt = word_over_r;
                  cnt_nxt = word_len_r + LEN_W'(1);
                end else begin
                  ovf_nxt = 1'b1;
                  cnt_nxt = LEN_W'(WORD_DEPTH - 1);
                end
                if (word_over_r || (word_len_r == LEN_W'(WORD_DEPTH))) begin
                  ovf_nxt = 1'b1;
                  cnt_nxt = LEN_W'(WORD_DEPTH - 1);
                end
                state_nxt = S_RD;
              end else begin
                pen_x_nxt = add_sum;
              end
            end
          endcase
        end
      end

      S_RD: begin
        // RAM read of entry k is in flight
        state_nxt = S_EMIT;
      end

      S_EMIT: begin
        // Re-place one buffered glyph and advance the pen
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.glyph_index   = word_first_r + 16'(k_r);
          out_data_nxt.pos_x         = clamp_out(pen_x_r);
          out_data_nxt.pos_y         = clamp_out(pen_y_r);
          out_data_nxt.placed        = 1'b1;
          out_data_nxt.word_overflow = ovf_r;
          out_data_nxt.last          = 1'b0;
          pen_x_nxt                  = add_sum;
          k_nxt                      = k_r + LEN_W'(1);
          if (k_r == cnt_r - LEN_W'(1)) begin
            if (ovf_r) begin
              state_nxt = S_TAIL;
            end else begin
              out_data_nxt.last = 1'b1;
              word_len_nxt      = '0;
              word_over_nxt     = 1'b0;
              word_first_nxt    = idx_r + 16'd1;
              state_nxt         = S_IDLE;
            end
          end else begin
            state_nxt = S_RD;
          end
        end
      end

      S_TAIL: begin
        // Place the current glyph after an overflowed word
        if (slot_free) begin
          out_valid_nxt              = 1'b1;
          out_data_nxt.glyph_index   = idx_r;
          out_data_nxt.pos_x         = clamp_out(pen_x_r);
          out_data_nxt.pos_y         = clamp_out(pen_y_r);
          out_data_nxt.placed        = 1'b1;
          out_data_nxt.word_overflow = 1'b1;
          out_data_nxt.last          = 1'b1;
          pen_x_nxt                  = add_sum;
          word_len_nxt               = '0;
          word_over_nxt              = 1'b0;
          word_first_nxt             = idx_r + 16'd1;
          state_nxt                  = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and pen state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      pen_x_r      <= '0;
      pen_y_r      <= '0;
      word_len_r   <= '0;
      word_over_r  <= 1'b0;
      word_first_r <= '0;
      next_index_r <= '0;
      k_r          <= '0;
      cnt_r        <= '0;
      ovf_r        <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      pen_x_r      <= pen_x_nxt;
      pen_y_r      <= pen_y_nxt;
      word_len_r   <= word_len_nxt;
      word_over_r  <= word_over_nxt;
      word_first_r <= word_first_nxt;
      next_index_r <= next_index_nxt;
      k_r          <= k_nxt;
      cnt_r        <= cnt_nxt;
      ovf_r        <= ovf_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    item_r     <= item_nxt;
    idx_r      <= idx_nxt;
    out_data_r <= out_data_nxt;
  end

endmodule

### rtl/core/gwwl_ram.sv
// ----------------------------------------------------------------------------
// gwwl_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module gwwl_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### tb/tb_greedy_word_wrap_layout_core.sv
// ----------------------------------------------------------------------------
// tb_greedy_word_wrap_layout_core
// Self-checking bench for the greedy word-wrap glyph placer. It drives glyph
// transactions and register writes, predicts every placement in a local
// model of the pen and the word buffer, and compares each result transaction
// in order. The run covers directed corner cases, word buffer overflow,
// large pen positions and random texts under several idle and stall mixes.
// ----------------------------------------------------------------------------
module tb_greedy_word_wrap_layout_core;
  timeunit 1ns;
  timeprecision 1ps;

  import gwwl_pkg::*;

  localparam logic [1:0] CLS_OTHER = 2'd3;
  localparam logic [23:0] MAX24 = 24'hFF_FFFF;

  logic clk;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  glyph_in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  glyph_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [3:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  greedy_word_wrap_layout_core dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // Idle and stall mix of the current phase, in percent
  int send_idle_pct = 0;
  int sink_stall_pct = 0;
  int glyphs_sent = 0;
  int mismatch_count = 0;

  // Layout model: registers, pen and word buffer
  logic [23:0] indent_reg;
  logic [23:0] step_reg;
  logic [31:0] wrap_reg;
  logic [31:0] pen_x;
  logic [31:0] pen_y;
  logic [15:0] word_adv [WORD_DEPTH];
  int word_len;
  logic [15:0] word_first;
  logic [15:0] next_idx;
  bit word_ovf;

  glyph_out_t expected_placements[$];
  glyph_out_t held_placement;
  bit held_valid;
  glyph_out_t want;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Saturating pen arithmetic
  function automatic logic [31:0] pen_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

  function automatic bit past_wrap(input bit brk);
    return brk && (wrap_reg != NO_WRAP) && (pen_x > wrap_reg);
  endfunction

  function automatic glyph_in_t make_glyph(input logic [1:0] cls, input logic [15:0] adv,
                                           input bit brk, input bit first);
    glyph_in_t g;
    g.glyph_class = cls;
    g.advance = adv;
    g.next_breaks = brk;
    g.first_glyph = first;
    return g;
  endfunction

  // Queue the previous placement and hold this one until the step ends
  function automatic void emit_placement(input logic [15:0] idx, input logic [31:0] x,
                                         input logic [31:0] y, input bit placed,
                                         input bit ovf);
    if (held_valid) begin
      expected_placements.insert(expected_placements.size(), held_placement);
    end
    held_placement.glyph_index = idx;
    held_placement.pos_x = x;
    held_placement.pos_y = y;
    held_placement.placed = placed;
    held_placement.word_overflow = ovf;
    held_placement.last = 1'b0;
    held_valid = 1'b1;
  endfunction

  function automatic void close_word(input logic [15:0] idx);
    word_len = 0;
    word_ovf = 1'b0;
    word_first = idx + 16'd1;
  endfunction

  // Predict all placements caused by one accepted glyph
  function automatic void place_glyph(input glyph_in_t g);
    logic [15:0] idx;
    logic [31:0] start_x;
    held_valid = 1'b0;
    if (g.first_glyph) begin
      pen_x = {8'd0, indent_reg};
      pen_y = '0;
      word_len = 0;
      word_ovf = 1'b0;
      word_first = '0;
      next_idx = '0;
    end
    idx = next_idx;
    next_idx = idx + 16'd1;
    case (g.glyph_class)
      CLS_SPACE: begin
        close_word(idx);
        if (pen_x == 0) begin
          emit_placement(idx, pen_x, pen_y, 1'b0, 1'b0);
        end else begin
          emit_placement(idx, pen_x, pen_y, 1'b1, 1'b0);
          pen_x = pen_add(pen_x, {16'd0, g.advance});
          if (past_wrap(g.next_breaks)) begin
            pen_x = '0;
            pen_y = pen_add(pen_y, {8'd0, step_reg});
          end
        end
      end
      CLS_NEWLINE: begin
        emit_placement(idx, pen_x, pen_y, 1'b1, 1'b0);
        pen_x = '0;
        pen_y = pen_add(pen_y, {8'd0, step_reg});
        close_word(idx);
      end
      default: begin
        // Ordinary glyph, and the unused class treated the same way
        start_x = pen_x;
        if (word_len < WORD_DEPTH) begin
          word_adv[ADDR_W'(word_len)] = g.advance;
          word_len++;
        end else begin
          word_ovf = 1'b1;
        end
        pen_x = pen_add(pen_x, {16'd0, g.advance});
        if (past_wrap(g.next_breaks)) begin
          pen_x = '0;
          pen_y = pen_add(pen_y, {8'd0, step_reg});
          if (!word_ovf) begin
            for (int k = 0; k < word_len; k++) begin
              emit_placement(word_first + 16'(k), pen_x, pen_y, 1'b1, 1'b0);
              pen_x = pen_add(pen_x, {16'd0, word_adv[ADDR_W'(k)]});
            end
          end else begin
            for (int k = 0; k < WORD_DEPTH - 1; k++) begin
              emit_placement(word_first + 16'(k), pen_x, pen_y, 1'b1, 1'b1);
              pen_x = pen_add(pen_x, {16'd0, word_adv[ADDR_W'(k)]});
            end
            emit_placement(idx, pen_x, pen_y, 1'b1, 1'b1);
            pen_x = pen_add(pen_x, {16'd0, g.advance});
          end
          close_word(idx);
        end else begin
          emit_placement(idx, start_x, pen_y, 1'b1, 1'b0);
        end
      end
    endcase
    held_placement.last = 1'b1;
    expected_placements.insert(expected_placements.size(), held_placement);
  endfunction

  // Send one glyph transaction; valid stays high afterward
  task automatic send_glyph(input glyph_in_t g);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= g;
    do @(posedge clk); while (!in_ready);
    place_glyph(g);
    glyphs_sent++;
  endtask

  // Hold the input until every expected placement has arrived
  task automatic wait_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_placements.size() != 0);
  endtask

  // APB write: setup phase and access phase, then the bus returns to idle
  task automatic write_reg(input logic [1:0] idx, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    case (idx)
      REG_FIRST_INDENT: indent_reg = value[23:0];
      REG_LINE_STEP:    step_reg = value[23:0];
      REG_WRAP_WIDTH:   wrap_reg = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic set_layout(input logic [23:0] indent, input logic [23:0] step,
                            input logic [31:0] wrap);
    write_reg(REG_FIRST_INDENT, {8'd0, indent});
    write_reg(REG_LINE_STEP, {8'd0, step});
    write_reg(REG_WRAP_WIDTH, wrap);
  endtask

  // Corner cases: skipped spaces, wraps, newlines, unused class, new text
  task automatic test_directed_cases();
    send_idle_pct = 0;
    sink_stall_pct = 0;
    set_layout(24'd0, 24'd1000, 32'd5000);
    send_glyph(make_glyph(CLS_SPACE, 16'd500, 1'b0, 1'b1));
    send_glyph(make_glyph(CLS_ORDINARY, 16'd0, 1'b0, 1'b0));
    send_glyph(make_glyph(CLS_ORDINARY, 16'd2000, 1'b1, 1'b0));
    send_glyph(make_glyph(CLS_SPACE, 16'd1000, 1'b0, 1'b0));
    send_glyph(make_glyph(CLS_ORDINARY, 16'd1500, 1'b0, 1'b0));
    send_glyph(make_glyph(CLS_ORDINARY, 16'd1000, 1'b1, 1'b0));
    send_glyph(make_glyph(CLS_SPACE, 16'd3000, 1'b1, 1'b0));
    send_glyph(make_glyph(CLS_SPACE, 16'd700, 1'b1, 1'b0));
    send_glyph(make_glyph(CLS_NEWLINE, 16'd123, 1'b0, 1'b0));
    send_glyph(make_glyph(CLS_OTHER, 16'hFFFF, 1'b1, 1'b0));
    send_glyph(make_glyph(CLS_NEWLINE, 16'd0, 1'b1, 1'b0));
    // Let the block run empty before the next text
    wait_drain();
    send_glyph(make_glyph(CLS_ORDINARY, 16'hFFFF, 1'b0, 1'b1));
    send_glyph(make_glyph(CLS_SPACE, 16'd0, 1'b1, 1'b0));
    send_glyph(make_glyph(CLS_ORDINARY, 16'h5555, 1'b0, 1'b0));
    send_glyph(make_glyph(CLS_ORDINARY, 16'hAAAA, 1'b1, 1'b0));
    wait_drain();
    write_reg(REG_FIRST_INDENT, {8'd0, MAX24});
    send_glyph(make_glyph(CLS_ORDINARY, 16'd100, 1'b1, 1'b1));
    send_glyph(make_glyph(CLS_NEWLINE, 16'd7, 1'b0, 1'b1));
    send_glyph(make_glyph(CLS_SPACE, 16'd10, 1'b0, 1'b1));
    wait_drain();
  endtask

  // Words that fill the buffer exactly and words that overflow it
  task automatic test_word_overflow();
    send_idle_pct = 16;
    sink_stall_pct = 16;
    set_layout(24'd0, 24'd7168, 32'd200000);
    for (int j = 0; j < WORD_DEPTH; j++) begin
      send_glyph(make_glyph(CLS_ORDINARY, 16'd4000, j == WORD_DEPTH - 1, j == 0));
    end
    send_glyph(make_glyph(CLS_SPACE, 16'd500, 1'b0, 1'b0));
    for (int j = 0; j < WORD_DEPTH + 6; j++) begin
      send_glyph(make_glyph(CLS_ORDINARY, 16'($urandom_range(2000, 4000)),
                            j == WORD_DEPTH + 5, 1'b0));
    end
    wait_drain();
  endtask

  // Push pen_y and pen_x far out with maximum steps and advances, then wrap
  task automatic test_large_positions();
    send_idle_pct = 0;
    sink_stall_pct = 0;
    set_layout(MAX24, MAX24, NO_WRAP);
    for (int j = 0; j < 12; j++) begin
      send_glyph(make_glyph(CLS_NEWLINE, 16'($urandom_range(65535)), 1'b0, j == 0));
    end
    for (int j = 0; j < 12; j++) begin
      send_glyph(make_glyph(CLS_ORDINARY, 16'hFFFF, 1'b0, 1'b0));
    end
    wait_drain();
    write_reg(REG_WRAP_WIDTH, 32'd1000);
    send_glyph(make_glyph(CLS_ORDINARY, 16'hFFFF, 1'b1, 1'b0));
    wait_drain();
  endtask

  // One text of random words, separators and occasional junk transactions
  task automatic send_random_text();
    int n_words;
    int wlen;
    int sep;
    bit first;
    bit brk;
    logic [1:0] cls;
    logic [15:0] adv;
    n_words = $urandom_range(1, 6);
    first = 1'b1;
    for (int w = 0; w < n_words; w++) begin
      // Separator after the word: 0 none (end), 1 one space, 2 two spaces, 3 newline
      if (w == n_words - 1) sep = 0;
      else if ($urandom_range(5) == 0) sep = 3;
      else sep = $urandom_range(1, 2);
      wlen = ($urandom_range(24) == 0) ? $urandom_range(60, 70) : $urandom_range(1, 8);
      for (int j = 0; j < wlen; j++) begin
        cls = ($urandom_range(15) == 0) ? CLS_OTHER : CLS_ORDINARY;
        adv = ($urandom_range(7) == 0) ? 16'($urandom_range(65535))
                                       : 16'($urandom_range(128, 3000));
        brk = (j == wlen - 1) && (sep != 3);
        if ($urandom_range(15) == 0) brk = ~brk;
        send_glyph(make_glyph(cls, adv, brk, first));
        first = 1'b0;
      end
      if (sep == 3) begin
        send_glyph(make_glyph(CLS_NEWLINE, 16'($urandom_range(65535)),
                              1'($urandom_range(1)), 1'b0));
      end else begin
        for (int s = 0; s < sep; s++) begin
          send_glyph(make_glyph(CLS_SPACE, 16'($urandom_range(200, 6000)),
                                s < sep - 1, 1'b0));
        end
      end
      if ($urandom_range(11) == 0) begin
        send_glyph(make_glyph(2'($urandom_range(3)), 16'($urandom_range(65535)),
                              1'($urandom_range(1)), 1'($urandom_range(1))));
      end
    end
  endtask

  task automatic test_random_texts(input int idle_pct, input int stall_pct,
                                   input logic [23:0] indent, input logic [23:0] step,
                                   input logic [31:0] wrap);
    int target;
    wait_drain();
    send_idle_pct = idle_pct;
    sink_stall_pct = stall_pct;
    set_layout(indent, step, wrap);
    target = glyphs_sent + 25;
    while (glyphs_sent < target) begin
      send_random_text();
    end
    wait_drain();
  endtask

  // Result side: random back-pressure
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= sink_stall_pct);
  end

  // Compare each result transaction with the oldest expected placement
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_placements.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10) begin
          $display("unexpected placement: idx=%0d x=%0d y=%0d", out_data.glyph_index,
                   out_data.pos_x, out_data.pos_y);
        end
      end else begin
        want = expected_placements.pop_front();
        if (out_data !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("placement mismatch: expected idx=%0d x=%0d y=%0d pl=%0b ovf=%0b last=%0b",
                     want.glyph_index, want.pos_x, want.pos_y, want.placed,
                     want.word_overflow, want.last);
            $display("                    actual   idx=%0d x=%0d y=%0d pl=%0b ovf=%0b last=%0b",
                     out_data.glyph_index, out_data.pos_x, out_data.pos_y, out_data.placed,
                     out_data.word_overflow, out_data.last);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    #4ms;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    // Model state after reset
    indent_reg = FIRST_INDENT_RST;
    step_reg = LINE_STEP_RST;
    wrap_reg = WRAP_WIDTH_RST;
    pen_x = '0;
    pen_y = '0;
    word_len = 0;
    word_first = '0;
    next_idx = '0;
    word_ovf = 1'b0;
    held_valid = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_cases();
    test_word_overflow();
    test_large_positions();
    test_random_texts(0, 0, 24'd1000, 24'd7168, 32'd20000);
    test_random_texts(64, 0, MAX24, 24'd0, 32'd0);
    test_random_texts(0, 64, 24'd0, MAX24, 32'd30000);
    test_random_texts(16, 16, 24'($urandom_range(4000)), 24'($urandom_range(1, 20000)),
                      32'd25000);

    // Drain, then allow for the longest rewrap
    wait_drain();
    repeat (200) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
